// File: rtl/assert_macros.svh
// assertion macros used by the selector top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define UCB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UCB_ASSERT(lbl, clk, rst, prop, msg)
`define UCB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/ucb_pkg.sv
// constants shared by the ucb1 arm selector
package ucb_pkg;
  localparam int ARM_COUNT_MAX = 16;
  localparam int ARM_W   = $clog2(ARM_COUNT_MAX);
  localparam int CFG_W   = 5;
  localparam int CMD_W   = 2;
  localparam int REW_W   = 16;
  localparam int DRAW_W  = 16;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int DIV_W   = 64;
  localparam int FRAC_W  = 16;
  localparam int LN_W    = 21;
  localparam int LG_W    = 21;
  localparam int RAD_W   = 40;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SCORE_W = 64;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
endpackage

// File: rtl/ucb_in_if.sv
// command word channel
interface ucb_in_if;
  logic                            valid;
  logic                            ready;
  logic [ucb_pkg::CMD_W-1:0]       cmd;
  logic [ucb_pkg::ARM_W-1:0]       arm;
  logic signed [ucb_pkg::REW_W-1:0] reward;
  logic [ucb_pkg::DRAW_W-1:0]      random_draw;
  modport source (output valid, cmd, arm, reward, random_draw, input ready);
  modport sink (input valid, cmd, arm, reward, random_draw, output ready);
endinterface

// File: rtl/ucb_out_if.sv
// selection result channel
interface ucb_out_if;
  logic                      valid;
  logic                      ready;
  logic [ucb_pkg::ARM_W-1:0] chosen_arm;
  logic                      from_unvisited;
  modport source (output valid, chosen_arm, from_unvisited, input ready);
  modport sink (input valid, chosen_arm, from_unvisited, output ready);
endinterface

// File: rtl/ucb1_bandit_arm_selector.sv
// ucb1 arm selector top level: statistics, sequencer and result register
//
//  channel   dir   payload
//  in_ch     in    cmd, arm, reward, random_draw
//  out_ch    out   chosen_arm, from_unvisited (select only)
//  cfg       in    cfg_wdata = arms_in_use
//
// update and clear act on the statistics as the word is taken. a select first walks the
// a arms in use; an unvisited pick adds a divide of the draw and a second walk over at most
// the a arms. a score pick adds the log unit and per arm two divides on the shared divider
// plus a root. reset is synchronous and clears all statistics at once. a result waits in
// the output register while a new word is taken; a select finishing with the register
// still full holds there.
module ucb1_bandit_arm_selector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ucb_pkg::CFG_W-1:0]   cfg_wdata,
  ucb_in_if.sink                      in_ch,
  ucb_out_if.source                   out_ch
);
  `include "assert_macros.svh"

  localparam int AW = ucb_pkg::ARM_W;
  localparam int SW = ucb_pkg::SUM_W;
  localparam int NW = ucb_pkg::CNT_W;
  localparam int QW = ucb_pkg::SCORE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COUNT = 4'd1;
  localparam logic [3:0] S_KDIV  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_LOG   = 4'd4;
  localparam logic [3:0] S_MEAN  = 4'd5;
  localparam logic [3:0] S_RAD   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [ucb_pkg::CFG_W-1:0]  arms_in_use;
  logic [ucb_pkg::CFG_W-1:0]  act;
  logic signed [SW-1:0]       reward_sum [ucb_pkg::ARM_COUNT_MAX];
  logic [NW-1:0]              arm_visit_count [ucb_pkg::ARM_COUNT_MAX];
  logic [NW-1:0]              total_visit_count;
  logic [ucb_pkg::ARM_COUNT_MAX-1:0] unv_mask;

  logic [3:0]                 state;
  logic [AW-1:0]              idx;
  logic [AW:0]                unv_cnt;
  logic [AW:0]                unv_cnt_next;
  logic [AW-1:0]              k;
  logic [ucb_pkg::DRAW_W-1:0] draw;
  logic [ucb_pkg::LN_W-1:0]   ln_reg;
  logic signed [QW-1:0]       mean_reg;
  logic signed [QW-1:0]       best;
  logic [AW-1:0]              lead_arm;
  logic [AW-1:0]              res_arm;
  logic                       res_unv;
  logic                       out_valid;
  logic                       in_fire;
  logic                       last;
  logic                       emit_go;

  logic                       div_start, sqrt_start, log_start;
  logic                       div_done, sqrt_done, log_done;
  logic [ucb_pkg::DIV_W-1:0]  div_dividend, div_quo;
  logic [NW-1:0]              div_divisor, div_rem;
  logic [ucb_pkg::ROOT_W-1:0] root;
  logic [ucb_pkg::LN_W-1:0]   ln_val;

  logic signed [SW-1:0]       cur_sum;
  logic [SW-1:0]              cur_mag;
  logic [NW-1:0]              cur_n;
  logic [QW:0]                sum_ext;
  logic signed [QW-1:0]       score;
  logic                       take;
  logic [SW:0]                upd_sum;

  assign act = (arms_in_use == '0) ? ucb_pkg::CFG_W'(1) :
               (arms_in_use > ucb_pkg::CFG_W'(ucb_pkg::ARM_COUNT_MAX)) ?
               ucb_pkg::CFG_W'(ucb_pkg::ARM_COUNT_MAX) : arms_in_use;
  assign last    = {{(ucb_pkg::CFG_W-AW){1'b0}}, idx} == act - ucb_pkg::CFG_W'(1);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign emit_go = !out_valid || out_ch.ready;

  assign out_ch.valid = out_valid;
  assign unv_cnt_next = unv_cnt + {{AW{1'b0}}, unv_mask[idx]};

  assign cur_sum = reward_sum[idx];
  assign cur_mag = cur_sum[SW-1] ? SW'(-cur_sum) : cur_sum;
  assign cur_n   = (arm_visit_count[idx] == '0) ? NW'(1) : arm_visit_count[idx];

  always_comb begin
    div_dividend = '0;
    div_divisor  = cur_n;
    case (state)
      S_KDIV: begin
        div_dividend = ucb_pkg::DIV_W'(draw);
        div_divisor  = NW'(unv_cnt);
      end
      S_MEAN: div_dividend = {cur_mag, ucb_pkg::FRAC_W'(0)};
      default: div_dividend = ucb_pkg::DIV_W'({ln_reg, 17'b0});
    endcase
  end

  // mean plus confidence term, saturated at the top of the signed range
  assign sum_ext = {mean_reg[QW-1], mean_reg} + (QW+1)'(root);
  assign score   = (sum_ext[QW:QW-1] == 2'b01) ? {1'b0, {(QW-1){1'b1}}} : sum_ext[QW-1:0];
  assign take    = (idx == '0) || (score > best);

  assign upd_sum = {reward_sum[in_ch.arm][SW-1], reward_sum[in_ch.arm]}
                 + (SW+1)'(in_ch.reward);

  ucb_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  ucb_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .rad(div_quo[ucb_pkg::RAD_W-1:0]),
    .done(sqrt_done), .root(root)
  );

  ucb_log u_log (
    .clk, .rst, .start(log_start), .x(total_visit_count), .done(log_done), .ln(ln_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arms_in_use <= ucb_pkg::CFG_W'(16);
    end else if (cfg_we) begin
      arms_in_use <= cfg_wdata;
    end
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst || (in_fire && in_ch.cmd == ucb_pkg::CMD_CLEAR)) begin
      for (int i = 0; i < ucb_pkg::ARM_COUNT_MAX; i++) begin
        reward_sum[i]      <= '0;
        arm_visit_count[i] <= '0;
      end
      total_visit_count <= '0;
      unv_mask          <= '1;
    end else if (in_fire && in_ch.cmd == ucb_pkg::CMD_UPDATE) begin
      if (upd_sum[SW] != upd_sum[SW-1])
        reward_sum[in_ch.arm] <= upd_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      else
        reward_sum[in_ch.arm] <= upd_sum[SW-1:0];
      if (arm_visit_count[in_ch.arm] != '1)
        arm_visit_count[in_ch.arm] <= arm_visit_count[in_ch.arm] + NW'(1);
      if (total_visit_count != '1) total_visit_count <= total_visit_count + NW'(1);
      unv_mask[in_ch.arm] <= 1'b0;
    end
  end

  // select sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      log_start  <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      log_start  <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire && in_ch.cmd == ucb_pkg::CMD_SELECT) begin
          draw    <= in_ch.random_draw;
          idx     <= '0;
          unv_cnt <= '0;
          state   <= S_COUNT;
        end
        S_COUNT: begin
          unv_cnt <= unv_cnt_next;
          idx     <= idx + AW'(1);
          if (last) begin
            idx <= '0;
            if (unv_cnt_next == '0) begin
              state     <= S_LOG;
              log_start <= 1'b1;
            end else begin
              state     <= S_KDIV;
              div_start <= 1'b1;
            end
          end
        end
        S_KDIV: if (div_done) begin
          k     <= div_rem[AW-1:0];
          state <= S_WALK;
        end
        S_WALK: begin
          idx <= idx + AW'(1);
          if (unv_mask[idx]) begin
            if (k == '0) begin
              res_arm <= idx;
              res_unv <= 1'b1;
              state   <= S_EMIT;
            end else begin
              k <= k - AW'(1);
            end
          end
        end
        S_LOG: if (log_done) begin
          ln_reg    <= ln_val;
          state     <= S_MEAN;
          div_start <= 1'b1;
        end
        S_MEAN: if (div_done) begin
          mean_reg  <= cur_sum[SW-1] ? QW'(-div_quo) : div_quo;
          state     <= S_RAD;
          div_start <= 1'b1;
        end
        S_RAD: if (div_done) begin
          state      <= S_SQRT;
          sqrt_start <= 1'b1;
        end
        S_SQRT: if (sqrt_done) begin
          if (take) begin
            best     <= score;
            lead_arm <= idx;
          end
          if (last) begin
            res_arm <= take ? idx : lead_arm;
            res_unv <= 1'b0;
            state   <= S_EMIT;
          end else begin
            idx       <= idx + AW'(1);
            state     <= S_MEAN;
            div_start <= 1'b1;
          end
        end
        S_EMIT: if (emit_go) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word valid: set on emit, cleared when taken with nothing new behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      out_ch.chosen_arm     <= res_arm;
      out_ch.from_unvisited <= res_unv;
    end
  end

  `UCB_ASSERT(a_kdiv_rem, clk, rst, (state == S_KDIV && div_done) |-> (div_rem < NW'(unv_cnt)), "draw remainder not below unvisited count")
  `UCB_ASSERT(a_walk_range, clk, rst, (state == S_WALK) |-> ({1'b0, idx} < act), "unvisited walk ran past arms in use")
  `UCB_ASSERT_ALWAYS(a_clear_mask, clk, (!rst && in_fire && in_ch.cmd == ucb_pkg::CMD_CLEAR) |=> (unv_mask == '1), "clear left an arm marked visited")
endmodule

// File: rtl/ucb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ucb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ucb_pkg::DIV_W-1:0]   dividend,
  input  logic [ucb_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [ucb_pkg::DIV_W-1:0]   quo,
  output logic [ucb_pkg::CNT_W-1:0]   rem
);
  localparam int STEP_W = $clog2(ucb_pkg::DIV_W + 1);

  logic [ucb_pkg::CNT_W-1:0] dvs;
  logic [STEP_W-1:0]         steps;
  logic                      busy;
  logic [ucb_pkg::CNT_W:0]   shifted;
  logic                      fits;

  assign shifted = {rem, quo[ucb_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(ucb_pkg::DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? ucb_pkg::CNT_W'(shifted - {1'b0, dvs}) : shifted[ucb_pkg::CNT_W-1:0];
      quo <= {quo[ucb_pkg::DIV_W-2:0], fits};
    end
  end
endmodule

// File: rtl/ucb_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
module ucb_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ucb_pkg::RAD_W-1:0]    rad,
  output logic                         done,
  output logic [ucb_pkg::ROOT_W-1:0]   root
);
  localparam int STEP_W = $clog2(ucb_pkg::ROOT_W + 1);
  localparam int REM_W  = ucb_pkg::ROOT_W + 2;

  logic [ucb_pkg::RAD_W-1:0] v;
  logic [REM_W-1:0]          rem;
  logic [STEP_W-1:0]         steps;
  logic                      busy;
  logic [REM_W+1:0]          remsh;
  logic [REM_W+1:0]          trial;
  logic                      fits;

  assign remsh = {rem, v[ucb_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = remsh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(ucb_pkg::ROOT_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v    <= {v[ucb_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(remsh - trial) : remsh[REM_W-1:0];
      root <= {root[ucb_pkg::ROOT_W-2:0], fits};
    end
  end
endmodule

// File: rtl/ucb_log.sv
// natural log in q16: serial normalize, 16 squaring steps, scale by ln 2
module ucb_log (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ucb_pkg::CNT_W-1:0]  x,
  output logic                       done,
  output logic [ucb_pkg::LN_W-1:0]   ln
);
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_CHK  = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;
  localparam int P_W = $clog2(ucb_pkg::CNT_W);
  localparam int I_W = $clog2(ucb_pkg::FRAC_W);

  logic [2:0]                 state;
  logic [ucb_pkg::CNT_W-1:0]  norm;
  logic [P_W-1:0]             p;
  logic [I_W-1:0]             bitpos;
  logic [ucb_pkg::LG_W-1:0]   lg;
  logic [61:0]                sq;
  logic [52:0]                prod;
  logic [31:0]                t;

  // mantissa squared, back to q30
  assign t = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: if (start) begin
          if (x == '0) begin
            ln    <= '0;
            done  <= 1'b1;
          end else begin
            norm  <= x;
            p     <= P_W'(ucb_pkg::CNT_W - 1);
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (norm[ucb_pkg::CNT_W-1]) begin
            lg     <= {p, ucb_pkg::FRAC_W'(0)};
            norm   <= {1'b0, norm[ucb_pkg::CNT_W-1:1]};
            bitpos <= I_W'(ucb_pkg::FRAC_W - 1);
            state  <= L_SQ;
          end else begin
            norm <= {norm[ucb_pkg::CNT_W-2:0], 1'b0};
            p    <= p - P_W'(1);
          end
        end
        L_SQ: begin
          sq    <= norm[30:0] * norm[30:0];
          state <= L_CHK;
        end
        L_CHK: begin
          if (t[31]) begin
            norm       <= {1'b0, t[31:1]};
            lg[bitpos] <= 1'b1;
          end else begin
            norm <= t;
          end
          bitpos <= bitpos - I_W'(1);
          state  <= (bitpos == '0) ? L_MUL : L_SQ;
        end
        L_MUL: begin
          prod  <= lg * ucb_pkg::LN2_Q32;
          state <= L_OUT;
        end
        L_OUT: begin
          ln    <= prod[32 +: ucb_pkg::LN_W];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule

// File: dv/ucb1_bandit_arm_selector_tb.sv
// self-checking testbench for the ucb1 arm selector: directed table, then random words
module ucb1_bandit_arm_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ucb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SELECT_WAIT = 3000;
  localparam longint SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [ucb_pkg::ARM_W-1:0] arm;
    logic                      unv;
  } pick_t;

  typedef struct {
    logic [ucb_pkg::CMD_W-1:0]        cmd;
    logic [ucb_pkg::ARM_W-1:0]        arm;
    logic signed [ucb_pkg::REW_W-1:0] reward;
    logic [ucb_pkg::DRAW_W-1:0]       draw;
    bit                               typed;
    pick_t                            pick;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ucb_pkg::CFG_W-1:0] cfg_wdata = '0;
  int errors = 0;
  bit no_gaps = 1'b0;

  ucb_in_if in_ch ();
  ucb_out_if out_ch ();

  ucb1_bandit_arm_selector i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  // predictor state
  longint arm_sum [ucb_pkg::ARM_COUNT_MAX];
  int unsigned arm_visits [ucb_pkg::ARM_COUNT_MAX];
  int unsigned total_visits;
  logic [ucb_pkg::CFG_W-1:0] arms_cfg;
  pick_t picks_due [$];

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic longint unsigned ln_fix(int unsigned x);
    int p;
    longint unsigned y, lg;
    if (x == 0) return 0;
    p = 0;
    while (p < 31 && (x >> (p + 1)) != 0) p++;
    y = (64'(x) << 30) >> p;
    lg = 64'(p) << 16;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        lg = lg | (64'd1 << i);
      end
    end
    return (lg * 64'd2977044472) >> 32;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint ucb_score(int a);
    longint unsigned n, mag, q, ci;
    longint s, mean;
    n = (arm_visits[a] == 0) ? 64'd1 : 64'(arm_visits[a]);
    s = arm_sum[a];
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag << 16) / n;
    mean = (s < 0) ? -longint'(q) : longint'(q);
    ci = root_floor(((64'd2 * ln_fix(total_visits)) << 16) / n);
    if (mean > SCORE_MAX - longint'(ci)) return SCORE_MAX;
    return mean + longint'(ci);
  endfunction

  // applies one accepted word; returns 1 with the pick when a result is due
  function automatic bit apply_word(logic [ucb_pkg::CMD_W-1:0] cmd,
                                    logic [ucb_pkg::ARM_W-1:0] arm,
                                    logic signed [ucb_pkg::REW_W-1:0] reward,
                                    logic [ucb_pkg::DRAW_W-1:0] draw, output pick_t pick);
    int act, unv, k, sel;
    longint t, best, sc;
    pick = '0;
    case (cmd)
      ucb_pkg::CMD_UPDATE: begin
        t = arm_sum[arm] + longint'(reward);
        if (t > SUM_HI) t = SUM_HI;
        if (t < SUM_LO) t = SUM_LO;
        arm_sum[arm] = t;
        if (arm_visits[arm] != 32'hFFFF_FFFF) arm_visits[arm]++;
        if (total_visits != 32'hFFFF_FFFF) total_visits++;
        return 0;
      end
      ucb_pkg::CMD_CLEAR: begin
        foreach (arm_sum[i]) begin
          arm_sum[i] = 0;
          arm_visits[i] = 0;
        end
        total_visits = 0;
        return 0;
      end
      ucb_pkg::CMD_SELECT: begin
        act = (arms_cfg == 0) ? 1 :
              (arms_cfg > ucb_pkg::ARM_COUNT_MAX) ? ucb_pkg::ARM_COUNT_MAX : arms_cfg;
        unv = 0;
        for (int i = 0; i < act; i++) if (arm_visits[i] == 0) unv++;
        if (unv != 0) begin
          k = int'(draw) % unv;
          sel = act;
          for (int i = 0; i < act; i++) begin
            if (arm_visits[i] == 0) begin
              if (k == 0) begin
                sel = i;
                break;
              end
              k--;
            end
          end
          pick.arm = sel[ucb_pkg::ARM_W-1:0];
          pick.unv = 1'b1;
          return 1;
        end
        sel = 0;
        best = ucb_score(0);
        for (int i = 1; i < act; i++) begin
          sc = ucb_score(i);
          if (sc > best) begin
            best = sc;
            sel = i;
          end
        end
        pick.arm = sel[ucb_pkg::ARM_W-1:0];
        pick.unv = 1'b0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_word(stim_row_t row);
    int g;
    pick_t pick;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = row.cmd;
    in_ch.arm = row.arm;
    in_ch.reward = row.reward;
    in_ch.random_draw = row.draw;
    do @(posedge clk); while (!in_ch.ready);
    if (apply_word(row.cmd, row.arm, row.reward, row.draw, pick))
      picks_due.push_back(row.typed ? row.pick : pick);
    @(negedge clk);
  endtask

  // waits for the block to drain, then writes the arm count
  task automatic set_arms(logic [ucb_pkg::CFG_W-1:0] v);
    in_ch.valid = 1'b0;
    wait (picks_due.size() == 0);
    repeat (SELECT_WAIT) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    arms_cfg = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic stim_row_t mk(logic [ucb_pkg::CMD_W-1:0] c, int a, int r, int d,
                                   bit typed = 0, int pa = 0, bit pu = 0);
    stim_row_t w;
    w.cmd = c;
    w.arm = a[ucb_pkg::ARM_W-1:0];
    w.reward = r[ucb_pkg::REW_W-1:0];
    w.draw = d[ucb_pkg::DRAW_W-1:0];
    w.typed = typed;
    w.pick.arm = pa[ucb_pkg::ARM_W-1:0];
    w.pick.unv = pu;
    return w;
  endfunction

  // receiver: random stalls, long ones now and then
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_gaps && $urandom_range(9) < 3) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (picks_due.size() == 0) begin
        $error("result word with nothing expected: arm %0d", out_ch.chosen_arm);
        errors++;
      end else begin
        want = picks_due.pop_front();
        if (out_ch.chosen_arm !== want.arm) begin
          $error("chosen_arm expected %0d got %0d", want.arm, out_ch.chosen_arm);
          errors++;
        end
        if (out_ch.from_unvisited !== want.unv) begin
          $error("from_unvisited expected %0d got %0d", want.unv, out_ch.from_unvisited);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [ucb_pkg::CFG_W-1:0] arm_settings [8];
    int r;
    stim_row_t w;
    arm_settings = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd3, 5'd16};
    in_ch.valid = 1'b0;
    in_ch.cmd = ucb_pkg::CMD_UPDATE;
    in_ch.arm = '0;
    in_ch.reward = '0;
    in_ch.random_draw = '0;
    foreach (arm_sum[i]) begin
      arm_sum[i] = 0;
      arm_visits[i] = 0;
    end
    total_visits = 0;
    arms_cfg = 5'd16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part: all arms unvisited after reset
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 0, 1, 0, 1));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 15, 0, 15, 1, 15, 1));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 16, 1, 0, 1));
    rows.push_back(mk(ucb_pkg::CMD_UPDATE, 3, 32767, 0));
    rows.push_back(mk(ucb_pkg::CMD_UPDATE, 3, -32768, 0));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 3, 1, 4, 1));
    rows.push_back(mk(CMD_UNUSED, 7, 123, 9));
    rows.push_back(mk(ucb_pkg::CMD_CLEAR, 0, 0, 0));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 65535, 1, 15, 1));
    for (int i = 0; i < 16; i++)
      rows.push_back(mk(ucb_pkg::CMD_UPDATE, i, (i % 2) ? -32768 : 32767, 0));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 65535));
    rows.push_back(mk(ucb_pkg::CMD_UPDATE, 15, 32767, 0));
    rows.push_back(mk(ucb_pkg::CMD_SELECT, 0, 0, 0));
    foreach (rows[i]) send_word(rows[i]);

    // random part, one arm setting per phase
    foreach (arm_settings[p]) begin
      set_arms(arm_settings[p]);
      no_gaps = (p == 3);
      for (int n = 0; n < 60; n++) begin
        r = $urandom_range(99);
        w = mk(ucb_pkg::CMD_UPDATE, $urandom_range(15), $urandom_range(65535),
               $urandom_range(65535));
        if (r < 10) w.arm = ucb_pkg::ARM_W'($urandom_range(arms_cfg > 15 ? 15 : arms_cfg));
        if (r % 7 == 0) w.reward = (r % 2) ? 16'sh7FFF : 16'sh8000;
        if (r >= 70) w.cmd = ucb_pkg::CMD_SELECT;
        if (r >= 96) w.cmd = ucb_pkg::CMD_CLEAR;
        if (r >= 98) w.cmd = CMD_UNUSED;
        send_word(w);
      end
    end
    no_gaps = 1'b0;

    in_ch.valid = 1'b0;
    wait (picks_due.size() == 0);
    repeat (SELECT_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
